/* rtl/gmw_pkg.sv */
// Shared types and constants for the GPIO masked-write interrupt unit.
`default_nettype none

package gmw_pkg;

    localparam int DATA_W       = 32;
    localparam int HALF_W       = 16;
    localparam int NUM_PINS_DEF = 32;
    localparam int CFG_IDX_W    = 3;

    typedef enum logic [1:0] {
        ACT_READ   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_SAMPLE = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        REG_PENDING = 4'd0,
        REG_PINS    = 4'd1,
        REG_OUT     = 4'd2,
        REG_OUT_LO  = 4'd3,
        REG_OUT_HI  = 4'd4,
        REG_OE      = 4'd5,
        REG_OE_LO   = 4'd6,
        REG_OE_HI   = 4'd7
    } t_reg_sel;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IRQ_ENABLE  = 3'd0,
        CFG_TRIG_RISE   = 3'd1,
        CFG_TRIG_FALL   = 3'd2,
        CFG_TRIG_LVL_HI = 3'd3,
        CFG_TRIG_LVL_LO = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [DATA_W-1:0] irq_enable;
        logic [DATA_W-1:0] trig_rising;
        logic [DATA_W-1:0] trig_falling;
        logic [DATA_W-1:0] trig_level_high;
        logic [DATA_W-1:0] trig_level_low;
    } t_cfg;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [DATA_W-1:0] out_value;
        logic [DATA_W-1:0] out_enable;
        logic [DATA_W-1:0] irq_lines;
        logic              bad_register;
    } t_rsp;

endpackage

`default_nettype wire

/* rtl/gmw_req_if.sv */
// Request channel: bus access or pin sample, valid/ready handshake.
`default_nettype none

interface gmw_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [3:0]  reg_select;
    logic [31:0] write_data;
    logic [31:0] pins_in;

    modport source (output valid, action, reg_select, write_data, pins_in, input ready);
    modport sink   (input valid, action, reg_select, write_data, pins_in, output ready);
endinterface

`default_nettype wire

/* rtl/gmw_rsp_if.sv */
// Result channel: read data and output/interrupt status, valid/ready handshake.
`default_nettype none

interface gmw_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [31:0] out_value;
    logic [31:0] out_enable;
    logic [31:0] irq_lines;
    logic        bad_register;

    modport source (output valid, read_data, out_value, out_enable, irq_lines, bad_register,
                    input ready);
    modport sink   (input valid, read_data, out_value, out_enable, irq_lines, bad_register,
                    output ready);
endinterface

`default_nettype wire

/* rtl/gmw_cfg.sv */
// Interrupt enable and trigger configuration registers.
`default_nettype none

module gmw_cfg
    import gmw_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_we,
    input  wire [CFG_IDX_W-1:0] i_index,
    input  wire [DATA_W-1:0]    i_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (t_cfg_idx'(i_index))
                CFG_IRQ_ENABLE:  n_cfg.irq_enable      = i_data;
                CFG_TRIG_RISE:   n_cfg.trig_rising     = i_data;
                CFG_TRIG_FALL:   n_cfg.trig_falling    = i_data;
                CFG_TRIG_LVL_HI: n_cfg.trig_level_high = i_data;
                CFG_TRIG_LVL_LO: n_cfg.trig_level_low  = i_data;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/gmw_dp.sv */
// GPIO state registers with next-state and result logic for one request.
`default_nettype none

module gmw_dp
    import gmw_pkg::*;
#(
    parameter int NUM_PINS = NUM_PINS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_fire,
    input  wire [1:0]        i_action,
    input  wire [3:0]        i_reg_select,
    input  wire [DATA_W-1:0] i_write_data,
    input  wire [DATA_W-1:0] i_pins_in,
    input  t_cfg             i_cfg,
    output t_rsp             o_rsp
);

    logic [NUM_PINS-1:0] r_pin_level, n_pin_level;
    logic [NUM_PINS-1:0] r_drive_value, n_drive_value;
    logic [NUM_PINS-1:0] r_drive_enable, n_drive_enable;
    logic [NUM_PINS-1:0] r_pending, n_pending;

    logic [DATA_W-1:0]   dv_ext, de_ext;
    logic [DATA_W-1:0]   sel_lo, val_lo, sel_hi, val_hi;
    logic [DATA_W-1:0]   dv_lo, dv_hi, de_lo, de_hi;
    logic [NUM_PINS-1:0] now, hits;
    logic [DATA_W-1:0]   rd;
    logic                bad;
    logic                sel_ok;

    assign dv_ext = DATA_W'(r_drive_value);
    assign de_ext = DATA_W'(r_drive_enable);

    // masked half writes: mask in upper half of the data, values in lower half
    assign sel_lo = {{HALF_W{1'b0}}, i_write_data[DATA_W-1:HALF_W]};
    assign val_lo = {{HALF_W{1'b0}}, i_write_data[HALF_W-1:0]};
    assign sel_hi = {i_write_data[DATA_W-1:HALF_W], {HALF_W{1'b0}}};
    assign val_hi = {i_write_data[HALF_W-1:0], {HALF_W{1'b0}}};

    assign dv_lo = (dv_ext & ~sel_lo) | (val_lo & sel_lo);
    assign dv_hi = (dv_ext & ~sel_hi) | (val_hi & sel_hi);
    assign de_lo = (de_ext & ~sel_lo) | (val_lo & sel_lo);
    assign de_hi = (de_ext & ~sel_hi) | (val_hi & sel_hi);

    assign now  = i_pins_in[NUM_PINS-1:0];
    assign hits = (~r_pin_level & now & i_cfg.trig_rising[NUM_PINS-1:0])
                | (r_pin_level & ~now & i_cfg.trig_falling[NUM_PINS-1:0])
                | (now & i_cfg.trig_level_high[NUM_PINS-1:0])
                | (~now & i_cfg.trig_level_low[NUM_PINS-1:0]);

    assign sel_ok = (i_reg_select <= 4'(REG_OE_HI));

    always_comb begin
        n_pin_level    = r_pin_level;
        n_drive_value  = r_drive_value;
        n_drive_enable = r_drive_enable;
        n_pending      = r_pending;
        rd             = '0;
        bad            = 1'b0;
        case (t_action'(i_action))
            ACT_READ: begin
                bad = !sel_ok;
                case (t_reg_sel'(i_reg_select))
                    REG_PENDING: rd = DATA_W'(r_pending);
                    REG_PINS:    rd = DATA_W'(r_pin_level);
                    REG_OUT:     rd = dv_ext;
                    REG_OUT_LO:  rd = {{HALF_W{1'b0}}, dv_ext[HALF_W-1:0]};
                    REG_OUT_HI:  rd = {{HALF_W{1'b0}}, dv_ext[DATA_W-1:HALF_W]};
                    REG_OE:      rd = de_ext;
                    REG_OE_LO:   rd = {{HALF_W{1'b0}}, de_ext[HALF_W-1:0]};
                    REG_OE_HI:   rd = {{HALF_W{1'b0}}, de_ext[DATA_W-1:HALF_W]};
                    default:     rd = '0;
                endcase
            end
            ACT_WRITE: begin
                bad = !sel_ok;
                case (t_reg_sel'(i_reg_select))
                    REG_PENDING: n_pending      = r_pending & ~i_write_data[NUM_PINS-1:0];
                    REG_OUT:     n_drive_value  = i_write_data[NUM_PINS-1:0];
                    REG_OUT_LO:  n_drive_value  = dv_lo[NUM_PINS-1:0];
                    REG_OUT_HI:  n_drive_value  = dv_hi[NUM_PINS-1:0];
                    REG_OE:      n_drive_enable = i_write_data[NUM_PINS-1:0];
                    REG_OE_LO:   n_drive_enable = de_lo[NUM_PINS-1:0];
                    REG_OE_HI:   n_drive_enable = de_hi[NUM_PINS-1:0];
                    default:     n_pending      = r_pending;
                endcase
            end
            ACT_SAMPLE: begin
                n_pending   = r_pending | hits;
                n_pin_level = now;
            end
            default: begin
                n_pending = r_pending;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_level    <= '0;
            r_drive_value  <= '0;
            r_drive_enable <= '0;
            r_pending      <= '0;
        end else if (i_fire) begin
            r_pin_level    <= n_pin_level;
            r_drive_value  <= n_drive_value;
            r_drive_enable <= n_drive_enable;
            r_pending      <= n_pending;
        end
    end

    assign o_rsp.read_data    = rd;
    assign o_rsp.out_value    = DATA_W'(n_drive_value);
    assign o_rsp.out_enable   = DATA_W'(n_drive_enable);
    assign o_rsp.irq_lines    = DATA_W'(n_pending & i_cfg.irq_enable[NUM_PINS-1:0]);
    assign o_rsp.bad_register = bad;

endmodule

`default_nettype wire

/* rtl/gpio_masked_write_irq_unit.sv */
// GPIO register block: masked output writes and edge/level interrupts (top level).
// Takes one request per clock unless results back up: bus read, bus write, pin
// sample or no-op. A request is held in an input register, processed against the
// GPIO state and its result placed in an output register, so the result is valid
// after the request has passed the input register and the result the output
// register; throughput is one request per cycle while results are taken; when a
// result waits, the input register holds one more request and then the input
// stalls until the result is taken. Pending interrupt bits are cleared by writing
// 1s to the pending register. Configuration writes take effect on the next clock.
`default_nettype none

module gpio_masked_write_irq_unit
    import gmw_pkg::*;
#(
    parameter int NUM_PINS = NUM_PINS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    gmw_req_if.sink             i_req,
    gmw_rsp_if.source           o_rsp,
    input  wire                 i_cfg_we,
    input  wire [CFG_IDX_W-1:0] i_cfg_index,
    input  wire [DATA_W-1:0]    i_cfg_data
);

    logic              r_in_vld;
    logic [1:0]        r_in_action;
    logic [3:0]        r_in_reg_select;
    logic [DATA_W-1:0] r_in_write_data;
    logic [DATA_W-1:0] r_in_pins_in;
    logic              r_out_vld;
    t_rsp              r_out;

    t_cfg cfg;
    t_rsp rsp;
    logic adv;
    logic fire;
    logic take;

    assign adv  = !r_out_vld || o_rsp.ready;
    assign fire = r_in_vld && adv;
    assign i_req.ready = !r_in_vld || adv;
    assign take = i_req.valid && i_req.ready;

    gmw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    gmw_dp #(
        .NUM_PINS (NUM_PINS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_action     (r_in_action),
        .i_reg_select (r_in_reg_select),
        .i_write_data (r_in_write_data),
        .i_pins_in    (r_in_pins_in),
        .i_cfg        (cfg),
        .o_rsp        (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_vld <= i_req.valid;
            end
            if (adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_action     <= i_req.action;
            r_in_reg_select <= i_req.reg_select;
            r_in_write_data <= i_req.write_data;
            r_in_pins_in    <= i_req.pins_in;
        end
        if (fire) begin
            r_out <= rsp;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.read_data    = r_out.read_data;
    assign o_rsp.out_value    = r_out.out_value;
    assign o_rsp.out_enable   = r_out.out_enable;
    assign o_rsp.irq_lines    = r_out.irq_lines;
    assign o_rsp.bad_register = r_out.bad_register;

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_vld)
        else $error("processed request produced no result");

    a_stall_keeps_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !adv) |=> (r_in_vld && $stable(r_in_write_data)))
        else $error("held request lost during output stall");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> i_req.ready)
        else $error("input stalled with empty result register");

    a_irq_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_out.irq_lines & ~cfg.irq_enable) == '0))
        else $error("interrupt line raised on a disabled pin");

endmodule

`default_nettype wire

/* bench/gpio_masked_write_irq_unit_tb.sv */
// Self-checking testbench for the GPIO masked-write interrupt unit.
`default_nettype none

module gpio_masked_write_irq_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gmw_pkg::*;

    localparam logic [DATA_W-1:0] PIN_MASK = DATA_W'((64'd1 << NUM_PINS_DEF) - 64'd1);
    localparam logic [3:0] SEL_UNUSED_FIRST = 4'd8;
    localparam logic [3:0] SEL_UNUSED_LAST  = 4'd15;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ACCESSES = 130;

    typedef struct packed {
        t_action           action;
        logic [3:0]        sel;
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] pins;
    } t_access;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;

    logic    drv_valid  = 1'b0;
    t_access drv_req    = '0;
    logic    take_ready = 1'b0;
    logic    req_fire   = 1'b0;

    gmw_req_if req_ch ();
    gmw_rsp_if rsp_ch ();

    assign req_ch.valid      = drv_valid;
    assign req_ch.action     = drv_req.action;
    assign req_ch.reg_select = drv_req.sel;
    assign req_ch.write_data = drv_req.data;
    assign req_ch.pins_in    = drv_req.pins;
    assign rsp_ch.ready      = take_ready;

    gpio_masked_write_irq_unit u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predicted GPIO state and settings
    t_cfg              gpio_cfg  = '0;
    logic [DATA_W-1:0] pin_q     = '0;
    logic [DATA_W-1:0] drive_val = '0;
    logic [DATA_W-1:0] drive_oe  = '0;
    logic [DATA_W-1:0] pend_q    = '0;

    t_access access_q [$];
    t_rsp    predicted_status_q [$];
    int      n_accesses    = 0;
    int      n_status_seen = 0;
    int      n_mismatch    = 0;
    int      idle_cycles   = 0;

    function automatic logic [DATA_W-1:0] merge_half(logic [DATA_W-1:0] cur,
                                                     logic [DATA_W-1:0] data, bit upper);
        logic [DATA_W-1:0] sel_bits;
        logic [DATA_W-1:0] val_bits;
        sel_bits = {{HALF_W{1'b0}}, data[DATA_W-1:HALF_W]};
        val_bits = {{HALF_W{1'b0}}, data[HALF_W-1:0]};
        if (upper) begin
            sel_bits = sel_bits << HALF_W;
            val_bits = val_bits << HALF_W;
        end
        return ((cur & ~sel_bits) | (val_bits & sel_bits)) & PIN_MASK;
    endfunction

    function automatic t_rsp next_status(t_access acc);
        t_rsp              res;
        logic [DATA_W-1:0] now;
        logic [DATA_W-1:0] hits;
        res = '0;
        if (acc.action == ACT_READ || acc.action == ACT_WRITE) begin
            if (acc.sel > REG_OE_HI) begin
                res.bad_register = 1'b1;
            end else if (acc.action == ACT_READ) begin
                case (t_reg_sel'(acc.sel))
                    REG_PENDING: res.read_data = pend_q;
                    REG_PINS:    res.read_data = pin_q;
                    REG_OUT:     res.read_data = drive_val;
                    REG_OUT_LO:  res.read_data = {{HALF_W{1'b0}}, drive_val[HALF_W-1:0]};
                    REG_OUT_HI:  res.read_data = {{HALF_W{1'b0}}, drive_val[DATA_W-1:HALF_W]};
                    REG_OE:      res.read_data = drive_oe;
                    REG_OE_LO:   res.read_data = {{HALF_W{1'b0}}, drive_oe[HALF_W-1:0]};
                    default:     res.read_data = {{HALF_W{1'b0}}, drive_oe[DATA_W-1:HALF_W]};
                endcase
            end else begin
                case (t_reg_sel'(acc.sel))
                    REG_PENDING: pend_q    = pend_q & ~acc.data;
                    REG_OUT:     drive_val = acc.data & PIN_MASK;
                    REG_OUT_LO:  drive_val = merge_half(drive_val, acc.data, 1'b0);
                    REG_OUT_HI:  drive_val = merge_half(drive_val, acc.data, 1'b1);
                    REG_OE:      drive_oe  = acc.data & PIN_MASK;
                    REG_OE_LO:   drive_oe  = merge_half(drive_oe, acc.data, 1'b0);
                    REG_OE_HI:   drive_oe  = merge_half(drive_oe, acc.data, 1'b1);
                    default: ;
                endcase
            end
        end else if (acc.action == ACT_SAMPLE) begin
            now  = acc.pins & PIN_MASK;
            hits = (~pin_q & now & gpio_cfg.trig_rising)
                 | (pin_q & ~now & gpio_cfg.trig_falling)
                 | (now & gpio_cfg.trig_level_high)
                 | (~now & gpio_cfg.trig_level_low);
            pend_q = (pend_q | hits) & PIN_MASK;
            pin_q  = now;
        end
        res.out_value  = drive_val;
        res.out_enable = drive_oe;
        res.irq_lines  = pend_q & gpio_cfg.irq_enable;
        return res;
    endfunction

    function automatic int unsigned pick_gap(bit steady);
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (want !== got) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("mismatch on %s: expected %08h, got %08h", name, want, got);
        end
    endtask

    // request driver
    int unsigned send_wait   = 0;
    int unsigned send_run    = 0;
    bit          send_steady = 1'b0;

    always @(negedge clk) begin
        if (!drv_valid || req_fire) begin
            if (send_wait != 0) begin
                send_wait--;
                drv_valid <= 1'b0;
            end else if (access_q.size() != 0) begin
                drv_req   <= access_q.pop_front();
                drv_valid <= 1'b1;
                if (send_run == 0) begin
                    send_steady = ($urandom_range(0, 3) == 0);
                    send_run    = $urandom_range(10, 60);
                end
                send_run--;
                send_wait = pick_gap(send_steady);
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // result receiver, with a long hold-off now and then so the unit backs up
    int unsigned stall_left  = 0;
    int unsigned hold_left   = 0;
    int unsigned take_run    = 0;
    bit          take_steady = 1'b0;
    int          hold_at     = 300;

    always @(negedge clk) begin
        logic        rdy;
        int unsigned g;
        if (n_status_seen >= hold_at) begin
            hold_at   += 400;
            hold_left  = 100;
        end
        if (hold_left != 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            rdy = 1'b0;
        end else begin
            if (take_run == 0) begin
                take_steady = ($urandom_range(0, 3) == 0);
                take_run    = $urandom_range(10, 60);
            end
            take_run--;
            g = pick_gap(take_steady);
            rdy = (g == 0);
            if (g != 0) stall_left = g - 1;
        end
        take_ready <= rdy;
    end

    // monitor and checker
    t_rsp    want_status;
    t_access got_access;

    always @(posedge clk) begin
        req_fire <= rst_n && drv_valid && req_ch.ready;
        if (rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                n_status_seen++;
                if (predicted_status_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result: read_data %08h", rsp_ch.read_data);
                end else begin
                    want_status = predicted_status_q.pop_front();
                    check_field("read_data", want_status.read_data, rsp_ch.read_data);
                    check_field("out_value", want_status.out_value, rsp_ch.out_value);
                    check_field("out_enable", want_status.out_enable, rsp_ch.out_enable);
                    check_field("irq_lines", want_status.irq_lines, rsp_ch.irq_lines);
                    check_field("bad_register", DATA_W'(want_status.bad_register),
                                DATA_W'(rsp_ch.bad_register));
                end
            end
            if (drv_valid && req_ch.ready) begin
                got_access.action = t_action'(req_ch.action);
                got_access.sel    = req_ch.reg_select;
                got_access.data   = req_ch.write_data;
                got_access.pins   = req_ch.pins_in;
                predicted_status_q.push_back(next_status(got_access));
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (drv_valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic program_settings(t_cfg s);
        t_cfg_idx          order [5] = '{CFG_IRQ_ENABLE, CFG_TRIG_RISE, CFG_TRIG_FALL,
                                         CFG_TRIG_LVL_HI, CFG_TRIG_LVL_LO};
        logic [DATA_W-1:0] vals  [5];
        vals = '{s.irq_enable, s.trig_rising, s.trig_falling, s.trig_level_high,
                 s.trig_level_low};
        for (int i = 0; i < 5; i++) begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= vals[i];
        end
        @(negedge clk);
        cfg_we   <= 1'b0;
        gpio_cfg  = s;
        @(posedge clk);
    endtask

    task automatic queue_access(t_action a, logic [3:0] s, logic [DATA_W-1:0] d,
                                logic [DATA_W-1:0] p);
        access_q.push_back('{action: a, sel: s, data: d, pins: p});
        n_accesses++;
    endtask

    initial begin
        t_cfg              s;
        t_action           a;
        logic [3:0]        sel;
        logic [DATA_W-1:0] d;
        logic [DATA_W-1:0] p;
        logic [DATA_W-1:0] last_pins;
        int unsigned       r;
        int                useful;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        s = '{irq_enable: '1, trig_rising: 32'h0000_00FF, trig_falling: 32'h0000_FF00,
              trig_level_high: 32'h00FF_0000, trig_level_low: 32'hFF00_0000};
        program_settings(s);

        queue_access(ACT_READ,   REG_PENDING, '0, '0);
        queue_access(ACT_READ,   REG_PINS,    '0, '0);
        queue_access(ACT_WRITE,  REG_OUT,     '1, '0);
        queue_access(ACT_WRITE,  REG_OUT_LO,  32'hFFFF_0000, '0);
        queue_access(ACT_WRITE,  REG_OUT_HI,  32'hF0F0_A5A5, '0);
        queue_access(ACT_WRITE,  REG_OE,      '0, '1);
        queue_access(ACT_WRITE,  REG_OE_LO,   '1, '0);
        queue_access(ACT_WRITE,  REG_OE_HI,   32'h0000_FFFF, '0);   // empty mask
        queue_access(ACT_READ,   REG_OUT,     '1, '0);
        queue_access(ACT_READ,   REG_OUT_LO,  '0, '0);
        queue_access(ACT_READ,   REG_OUT_HI,  '0, '0);
        queue_access(ACT_READ,   REG_OE,      '0, '0);
        queue_access(ACT_READ,   REG_OE_LO,   '0, '0);
        queue_access(ACT_READ,   REG_OE_HI,   '0, '0);
        queue_access(ACT_WRITE,  REG_PINS,    '1, '1);              // read-only, ignored
        queue_access(ACT_READ,   SEL_UNUSED_FIRST, '0, '1);
        queue_access(ACT_WRITE,  SEL_UNUSED_LAST,  '1, '1);
        queue_access(ACT_NOP,    REG_OUT,     '1, '1);
        queue_access(ACT_SAMPLE, REG_OUT,     '1, '1);
        queue_access(ACT_SAMPLE, REG_PENDING, '0, '0);
        queue_access(ACT_READ,   REG_PENDING, '0, '0);
        queue_access(ACT_WRITE,  REG_PENDING, '1, '0);
        queue_access(ACT_SAMPLE, REG_PINS,    '0, '1);
        queue_access(ACT_WRITE,  REG_PENDING, 32'h0000_FFFF, '0);
        queue_access(ACT_READ,   REG_PINS,    '0, '0);
        last_pins = '1;

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            while (n_status_seen != n_accesses) @(negedge clk);
            case (ph)
                0: s = '1;
                1: s = '0;
                default: begin
                    s.irq_enable      = $urandom;
                    s.trig_rising     = $urandom & $urandom;
                    s.trig_falling    = $urandom & $urandom;
                    s.trig_level_high = $urandom & $urandom & $urandom;
                    s.trig_level_low  = $urandom & $urandom & $urandom;
                end
            endcase
            program_settings(s);

            useful = 0;
            while (useful < PHASE_ACCESSES) begin
                r = $urandom_range(0, 99);
                a = (r < 35) ? ACT_READ : (r < 65) ? ACT_WRITE :
                    (r < 95) ? ACT_SAMPLE : ACT_NOP;
                sel = ($urandom_range(0, 9) == 0) ?
                      4'($urandom_range(SEL_UNUSED_FIRST, SEL_UNUSED_LAST)) :
                      4'($urandom_range(REG_PENDING, REG_OE_HI));
                d = $urandom;
                case ($urandom_range(0, 9))
                    0: d = '1;
                    1: d = '0;
                    2: d[DATA_W-1:HALF_W] = '1;
                    3: d = d & $urandom & $urandom;
                    default: ;
                endcase
                case ($urandom_range(0, 7))
                    0: p = '0;
                    1: p = '1;
                    2: p = ~last_pins;
                    3, 4: p = last_pins ^ ($urandom & $urandom & $urandom);
                    default: p = $urandom;
                endcase
                if (a == ACT_SAMPLE) last_pins = p;
                queue_access(a, sel, d, p);
                if (a == ACT_SAMPLE || (a != ACT_NOP && sel <= REG_OE_HI)) useful++;
            end
        end

        while (n_status_seen != n_accesses) @(negedge clk);
        repeat (20) @(negedge clk);
        if (n_mismatch == 0 && predicted_status_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/gmw_pkg.sv
rtl/gmw_req_if.sv
rtl/gmw_rsp_if.sv
rtl/gmw_cfg.sv
rtl/gmw_dp.sv
rtl/gpio_masked_write_irq_unit.sv
bench/gpio_masked_write_irq_unit_tb.sv
